/* hdl/mtfc_pkg.sv */
`default_nettype none

package mtfc_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH = 256;
    localparam int SYMBOL_BITS = 16;
    localparam int FIELD_BITS  = 16;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int SIZE_BITS   = $clog2(TABLE_DEPTH + 1);
    localparam int SPAN_BITS   = FIELD_BITS + 1;
    localparam int CFG_INDEX_BITS = 2;

    // Register reset values
    localparam logic [FIELD_BITS-1:0] LOWEST_RESET  = FIELD_BITS'(0);
    localparam logic [FIELD_BITS-1:0] HIGHEST_RESET = FIELD_BITS'(255);

    typedef logic [ADDR_BITS-1:0]  offset_t;
    typedef logic [SIZE_BITS-1:0]  size_t;
    typedef logic [FIELD_BITS-1:0] value_t;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOWEST  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGHEST = 2'd2;

    // Field codes
    localparam logic MODE_ENCODE   = 1'b0;
    localparam logic MODE_DECODE   = 1'b1;
    localparam logic CMD_RESTART   = 1'b0;
    localparam logic CMD_PROCESS   = 1'b1;
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_ERROR  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_MATCH
    } state_t;

    // Broadcast control for the cell row
    typedef struct packed {
        logic    load;     // reload ascending order
        logic    capture;  // latch compare result
        logic    shift;    // move the hit entry to the front
        logic    decode;   // compare on position instead of content
        logic    key_ok;   // key lies inside the dictionary
        offset_t key;      // offset or position to look for
        size_t   size;     // current dictionary size
        offset_t pos;      // position of the hit entry
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/mtfc_cell.sv */
`default_nettype none

module mtfc_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mtfc_pkg::offset_t   cell_index,
    input  mtfc_pkg::cell_ctrl_t ctrl,
    input  mtfc_pkg::offset_t   shift_in,
    output mtfc_pkg::offset_t   entry,
    output logic                hit
);

    mtfc_pkg::offset_t entry_reg;
    mtfc_pkg::offset_t entry_next;
    logic              hit_reg;
    logic              hit_next;
    logic              match;
    logic              in_dict;

    // Compare against the broadcast key
    always_comb
    begin
        in_dict = mtfc_pkg::SIZE_BITS'(cell_index) < ctrl.size;
        match   = ctrl.decode ? (cell_index == ctrl.key) : (entry_reg == ctrl.key);
        hit_next = ctrl.capture ? (ctrl.key_ok && match && in_dict) : hit_reg;
    end

    // Entry update: reload, take the neighbor's entry, or hold
    always_comb
    begin
        priority if (ctrl.load)
        begin
            entry_next = cell_index;
        end
        else if (ctrl.shift && (cell_index <= ctrl.pos))
        begin
            entry_next = shift_in;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= cell_index;
            hit_reg   <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            hit_reg   <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

/* hdl/mtfc_select.sv */
`default_nettype none

module mtfc_select (
    input  wire [mtfc_pkg::TABLE_DEPTH-1:0] hit_vec,
    input  mtfc_pkg::offset_t               entry_vec [mtfc_pkg::TABLE_DEPTH],
    output mtfc_pkg::offset_t               pos,
    output mtfc_pkg::offset_t               moved,
    output logic                            any_hit
);

    // At most one cell hits: OR-reduce its position and its entry
    always_comb
    begin
        pos     = '0;
        moved   = '0;
        any_hit = |hit_vec;
        for (int i = 0; i < mtfc_pkg::TABLE_DEPTH; i++)
        begin
            pos   = pos   | (mtfc_pkg::ADDR_BITS'(i) & {mtfc_pkg::ADDR_BITS{hit_vec[i]}});
            moved = moved | (entry_vec[i] & {mtfc_pkg::ADDR_BITS{hit_vec[i]}});
        end
    end

endmodule

`default_nettype wire

/* hdl/move_to_front_codec.sv */
// Process request: each cell latches its compare result at accept; once the output is
// free, the hit is reduced and the result registered. No request is taken until then.
// A waiting result that is not taken holds the row, and with it the next request.
// Restart request: table reloaded, no result; next request the cycle after.
// The cell row first compares the key in parallel in every cell,
// then reduces the hit and shifts the row toward the front.
// Reset: table in ascending order, mode encode, lowest 0, highest 255, no result.
`default_nettype none

module move_to_front_codec (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // request stream
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire [mtfc_pkg::FIELD_BITS-1:0]        s_tdata,   // [15:0] value
    input  wire                                   s_tuser,   // [0] command
    // result stream
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [mtfc_pkg::FIELD_BITS-1:0]       m_tdata,   // [15:0] result
    output logic                                  m_tuser,   // [0] status
    // configuration writes
    input  wire                                   cfg_wr_en,
    input  wire [mtfc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire [mtfc_pkg::FIELD_BITS-1:0]        cfg_data
);

    localparam int DEPTH = mtfc_pkg::TABLE_DEPTH;

    mtfc_pkg::state_t     state_reg;
    mtfc_pkg::state_t     state_next;
    mtfc_pkg::cell_ctrl_t ctrl;

    logic              mode_reg;
    mtfc_pkg::value_t  lowest_reg;
    mtfc_pkg::value_t  highest_reg;

    logic              m_valid_reg;
    logic              m_valid_next;
    mtfc_pkg::value_t  m_data_reg;
    mtfc_pkg::value_t  m_data_next;
    logic              m_user_reg;
    logic              m_user_next;

    logic [mtfc_pkg::SPAN_BITS-1:0] span;
    mtfc_pkg::size_t   dict_size;
    mtfc_pkg::value_t  enc_offset;
    mtfc_pkg::value_t  size_ext;
    mtfc_pkg::value_t  dec_symbol;
    logic [mtfc_pkg::SYMBOL_BITS-1:0] sym_full;
    logic              key_ok;
    mtfc_pkg::offset_t lookup_key;
    logic              accept;
    logic              out_free;
    logic              done;

    logic [DEPTH-1:0]  hit_vec;
    mtfc_pkg::offset_t entry_vec [DEPTH];
    mtfc_pkg::offset_t pos;
    mtfc_pkg::offset_t moved;
    logic              any_hit;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= mtfc_pkg::MODE_ENCODE;
            lowest_reg  <= mtfc_pkg::LOWEST_RESET;
            highest_reg <= mtfc_pkg::HIGHEST_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mtfc_pkg::REG_MODE:    mode_reg    <= cfg_data[0];
                mtfc_pkg::REG_LOWEST:  lowest_reg  <= cfg_data;
                mtfc_pkg::REG_HIGHEST: highest_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Dictionary size, capped at the table depth
    always_comb
    begin
        span = {1'b0, highest_reg} - {1'b0, lowest_reg} + mtfc_pkg::SPAN_BITS'(1);
        if (highest_reg < lowest_reg)
        begin
            dict_size = '0;
        end
        else if (span > mtfc_pkg::SPAN_BITS'(DEPTH))
        begin
            dict_size = mtfc_pkg::SIZE_BITS'(DEPTH);
        end
        else
        begin
            dict_size = span[mtfc_pkg::SIZE_BITS-1:0];
        end
    end

    // Key for the compare cycle
    always_comb
    begin
        size_ext   = mtfc_pkg::FIELD_BITS'(dict_size);
        enc_offset = s_tdata - lowest_reg;
        if (mode_reg == mtfc_pkg::MODE_DECODE)
        begin
            key_ok     = s_tdata < size_ext;
            lookup_key = s_tdata[mtfc_pkg::ADDR_BITS-1:0];
        end
        else
        begin
            key_ok     = (s_tdata >= lowest_reg) && (enc_offset < size_ext);
            lookup_key = enc_offset[mtfc_pkg::ADDR_BITS-1:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtfc_pkg::ST_IDLE:
            begin
                if (s_tvalid && (s_tuser == mtfc_pkg::CMD_PROCESS))
                begin
                    state_next = mtfc_pkg::ST_MATCH;
                end
            end
            mtfc_pkg::ST_MATCH:
            begin
                if (out_free)
                begin
                    state_next = mtfc_pkg::ST_IDLE;
                end
            end
            default: state_next = mtfc_pkg::ST_IDLE;
        endcase
    end

    // State outputs and row control
    always_comb
    begin
        out_free     = !m_valid_reg || m_tready;
        s_tready     = (state_reg == mtfc_pkg::ST_IDLE);
        accept       = s_tvalid && s_tready;
        done         = (state_reg == mtfc_pkg::ST_MATCH) && out_free;
        ctrl.load    = accept && (s_tuser == mtfc_pkg::CMD_RESTART);
        ctrl.capture = accept && (s_tuser == mtfc_pkg::CMD_PROCESS);
        ctrl.shift   = done && any_hit;
        ctrl.decode  = (mode_reg == mtfc_pkg::MODE_DECODE);
        ctrl.key_ok  = key_ok;
        ctrl.key     = lookup_key;
        ctrl.size    = dict_size;
        ctrl.pos     = pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtfc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Row of cells; cell 0 takes the moved entry, the others their neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        mtfc_pkg::offset_t shift_in;
        if (i == 0)
        begin : g_front
            assign shift_in = moved;
        end
        else
        begin : g_rest
            assign shift_in = entry_vec[i-1];
        end

        mtfc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (mtfc_pkg::ADDR_BITS'(i)),
            .ctrl       (ctrl),
            .shift_in   (shift_in),
            .entry      (entry_vec[i]),
            .hit        (hit_vec[i])
        );
    end

    mtfc_select u_select (
        .hit_vec   (hit_vec),
        .entry_vec (entry_vec),
        .pos       (pos),
        .moved     (moved),
        .any_hit   (any_hit)
    );

    // Result register
    always_comb
    begin
        sym_full   = mtfc_pkg::SYMBOL_BITS'(lowest_reg) + mtfc_pkg::SYMBOL_BITS'(moved);
        dec_symbol = mtfc_pkg::FIELD_BITS'(sym_full);
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (done)
        begin
            m_valid_next = 1'b1;
            m_user_next  = any_hit ? mtfc_pkg::STATUS_OK : mtfc_pkg::STATUS_ERROR;
            if (!any_hit)
            begin
                m_data_next = '0;
            end
            else if (ctrl.decode)
            begin
                m_data_next = dec_symbol;
            end
            else
            begin
                m_data_next = mtfc_pkg::FIELD_BITS'(pos);
            end
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // Entries form a permutation, so at most one cell can hit
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtfc_pkg::ST_MATCH) |-> $onehot0(hit_vec))
        else $error("more than one cell hit");

    // A finished match always leaves a valid result behind
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (m_tvalid && (state_reg == mtfc_pkg::ST_IDLE)))
        else $error("completed request gave no result");

    // After a shift the front cell holds the entry that was hit
    a_front_entry: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift |=> (entry_vec[0] == $past(moved)))
        else $error("hit entry not moved to front");

    // A restart request never produces a result
    a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> !$rose(m_tvalid))
        else $error("restart produced a result");
`endif

endmodule

`default_nettype wire
